// ----- rtl/tccs_pkg.sv -----
// Shared types and constants for the text console cursor/scroll engine.
package tccs_pkg;

  localparam int CH_W   = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CH_W + ATTR_W;

  localparam logic [CH_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SETCUR = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input request
    logic exec;    // perform the request's store and cursor work
    logic sweep;   // clear one cell at the sweep pointer
    logic result;  // load the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;     // sweep pointer sits on the last cell to clear
    logic scroll_needed;  // captured request scrolls the screen
  } dp_status_t;

endpackage

// ----- rtl/tccs_ctrl.sv -----
// Sequencer for the text console engine: handshakes and step order.
module tccs_ctrl import tccs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.exec   = (state_r == ST_EXEC);
    cmd.sweep  = (state_r == ST_CLEAR) || (state_r == ST_SWEEP);
    cmd.result = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (status.sweep_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r <= status.scroll_needed ? ST_SWEEP : ST_DONE;
        end
        ST_SWEEP: begin
          if (status.sweep_last) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

endmodule

// ----- rtl/tccs_dp.sv -----
// Datapath for the text console engine: cell store, cursor, top-row pointer.
module tccs_dp import tccs_pkg::*; #(
  parameter  int COLS  = 80,
  parameter  int ROWS  = 25,
  localparam int COL_W = $clog2(COLS),
  localparam int ROW_W = $clog2(ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic [1:0]        in_cmd,
  input  logic [CH_W-1:0]   in_ch,
  input  logic [ATTR_W-1:0] in_attr,
  input  logic [COL_W-1:0]  in_pos_col,
  input  logic [ROW_W-1:0]  in_pos_row,
  output logic [COL_W-1:0]  out_cursor_col,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic              out_scrolled,
  output logic [CH_W-1:0]   out_cell_char,
  output logic [ATTR_W-1:0] out_cell_attr
);

  localparam int NCELLS = COLS * ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam logic [COL_W:0]   COLS_C   = (COL_W+1)'(COLS);
  localparam logic [ROW_W:0]   ROWS_C   = (ROW_W+1)'(ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [CELL_W-1:0] mem [NCELLS];

  cmd_t              cmd_r;
  logic [CH_W-1:0]   ch_r;
  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  pcol_r;
  logic [ROW_W-1:0]  prow_r;

  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [ROW_W-1:0]  top_r;
  logic              scrolled_r;
  logic [AW-1:0]     sweep_addr_r;
  logic [AW-1:0]     sweep_end_r;
  logic [CELL_W-1:0] rd_data_r;
  logic              rd_sel_r;

  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_scr_r;
  logic [CELL_W-1:0] out_cell_r;

  logic              pos_on;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              wrap;
  logic              last_row;
  logic              is_put;
  logic              is_nl;
  logic              adv_row;
  logic              scroll_needed;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     pos_addr;
  logic [AW-1:0]     top_base;
  logic [ROW_W-1:0]  top_nxt;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;

  // Logical row to stored row: add the top-row pointer modulo ROWS.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, top};
    if (s >= ROWS_C) begin
      s = s - ROWS_C;
    end
    return s[ROW_W-1:0];
  endfunction

  assign pos_on        = ({1'b0, pcol_r} < COLS_C) && ({1'b0, prow_r} < ROWS_C);
  assign col_inc       = {1'b0, cur_col_r} + 1'b1;
  assign row_inc       = {1'b0, cur_row_r} + 1'b1;
  assign wrap          = (col_inc >= COLS_C);
  assign last_row      = (row_inc >= ROWS_C);
  assign is_put        = (cmd_r == CMD_PUT);
  assign is_nl         = (ch_r == NEWLINE_CODE);
  assign adv_row       = is_put && (is_nl || wrap);
  assign scroll_needed = adv_row && last_row;
  assign top_nxt       = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;

  assign cur_addr = AW'(phys_row(cur_row_r, top_r)) * AW'(COLS) + AW'(cur_col_r);
  assign pos_addr = AW'(phys_row(prow_r, top_r)) * AW'(COLS) + AW'(pcol_r);
  // The old top row becomes the new bottom row after a scroll
  assign top_base = AW'(top_r) * AW'(COLS);

  assign status.sweep_last    = (sweep_addr_r == sweep_end_r);
  assign status.scroll_needed = scroll_needed;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_addr_r;
    wr_data = '0;
    if (cmd.sweep) begin
      wr_en = 1'b1;
    end else if (cmd.exec) begin
      if (is_put && !is_nl) begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
        wr_data = {attr_r, ch_r};
      end else if ((cmd_r == CMD_WRITE) && pos_on) begin
        wr_en   = 1'b1;
        wr_addr = pos_addr;
        wr_data = {attr_r, ch_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.exec) begin
      rd_data_r <= mem[pos_addr];
    end
  end

  // Captured request and results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= cmd_t'(in_cmd);
      ch_r   <= in_ch;
      attr_r <= in_attr;
      pcol_r <= in_pos_col;
      prow_r <= in_pos_row;
    end
    if (cmd.exec) begin
      scrolled_r <= scroll_needed;
      rd_sel_r   <= (cmd_r == CMD_READ) && pos_on;
    end
    if (cmd.result) begin
      out_col_r  <= cur_col_r;
      out_row_r  <= cur_row_r;
      out_scr_r  <= scrolled_r;
      out_cell_r <= rd_sel_r ? rd_data_r : '0;
    end
  end

  // Cursor, top-row pointer and sweep range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      top_r        <= '0;
      sweep_addr_r <= '0;
      sweep_end_r  <= AW'(NCELLS - 1);
    end else if (cmd.sweep) begin
      sweep_addr_r <= sweep_addr_r + 1'b1;
    end else if (cmd.exec) begin
      unique case (cmd_r)
        CMD_PUT: begin
          if (adv_row) begin
            cur_col_r <= '0;
            if (last_row) begin
              cur_row_r    <= LAST_ROW;
              top_r        <= top_nxt;
              sweep_addr_r <= top_base;
              sweep_end_r  <= top_base + AW'(COLS - 1);
            end else begin
              cur_row_r <= row_inc[ROW_W-1:0];
            end
          end else begin
            cur_col_r <= col_inc[COL_W-1:0];
          end
        end
        CMD_SETCUR: begin
          if (pos_on) begin
            cur_col_r <= pcol_r;
            cur_row_r <= prow_r;
          end
        end
        CMD_READ, CMD_WRITE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_scrolled   = out_scr_r;
  assign out_cell_char  = out_cell_r[CH_W-1:0];
  assign out_cell_attr  = out_cell_r[CELL_W-1:CH_W];

endmodule

// ----- rtl/text_console_cursor_scroll.sv -----
// Top level of the text console engine: stream ports, sequencer and datapath.
//
// Text-mode console of COLS x ROWS cells (character byte plus attribute
// byte) with a cursor. Each request on the input stream yields exactly one
// result on the output stream. A request passes through capture, execute
// (at most one store write and one registered store read) and deliver,
// which loads the output register once the previous result has left it. A
// put-character that runs off the bottom row scrolls the screen. The scroll
// is a rotation of a top-row pointer, so only the new bottom row is cleared.
// It is cleared one cell per cycle through the single store write port,
// which lengthens that request. After reset the whole store is cleared with
// in_tready low. Requests are taken one at a time. The next request is
// accepted while the previous result still waits in the output register.
module text_console_cursor_scroll import tccs_pkg::*; #(
  parameter  int COLS   = 80,
  parameter  int ROWS   = 25,
  localparam int COL_W  = $clog2(COLS),
  localparam int ROW_W  = $clog2(ROWS),
  localparam int IN_W   = ((2 + CH_W + ATTR_W + COL_W + ROW_W + 7) / 8) * 8,
  localparam int OUT_W  = ((COL_W + ROW_W + 1 + CH_W + ATTR_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // cmd, ch, attr, pos_col, pos_row (lowest bits first), zero padding above
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // cursor_col, cursor_row, scrolled, cell_char, cell_attr (lowest first)
  output logic [OUT_W-1:0] out_tdata
);

  localparam int IN_USED  = 2 + CH_W + ATTR_W + COL_W + ROW_W;

  ctrl_cmd_t         cmd;
  dp_status_t        status;

  logic [1:0]        f_cmd;
  logic [CH_W-1:0]   f_ch;
  logic [ATTR_W-1:0] f_attr;
  logic [COL_W-1:0]  f_pos_col;
  logic [ROW_W-1:0]  f_pos_row;

  logic [COL_W-1:0]  r_cursor_col;
  logic [ROW_W-1:0]  r_cursor_row;
  logic              r_scrolled;
  logic [CH_W-1:0]   r_cell_char;
  logic [ATTR_W-1:0] r_cell_attr;

  // Unpack the request; padding bits are ignored
  assign {f_pos_row, f_pos_col, f_attr, f_ch, f_cmd} = in_tdata[IN_USED-1:0];

  // Pack the result with zero padding
  assign out_tdata = OUT_W'({r_cell_attr, r_cell_char, r_scrolled,
                             r_cursor_row, r_cursor_col});

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tccs_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_cmd         (f_cmd),
    .in_ch          (f_ch),
    .in_attr        (f_attr),
    .in_pos_col     (f_pos_col),
    .in_pos_row     (f_pos_row),
    .out_cursor_col (r_cursor_col),
    .out_cursor_row (r_cursor_row),
    .out_scrolled   (r_scrolled),
    .out_cell_char  (r_cell_char),
    .out_cell_attr  (r_cell_attr)
  );

endmodule

// ----- rtl/tccs_checker.sv -----
// Port-level checks for the text console engine, bound to the top level.
module tccs_checker import tccs_pkg::*; #(
  parameter  int COLS  = 80,
  parameter  int ROWS  = 25,
  localparam int COL_W = $clog2(COLS),
  localparam int ROW_W = $clog2(ROWS),
  localparam int IN_W  = ((2 + CH_W + ATTR_W + COL_W + ROW_W + 7) / 8) * 8,
  localparam int OUT_W = ((COL_W + ROW_W + 1 + CH_W + ATTR_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int SCR_BIT = COL_W + ROW_W;

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pending_r;
  logic       in_seen;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_seen  = ^in_tdata || !(^in_tdata);

  // Requests accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_fire && !out_fire) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_fire && !in_fire) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> (pending_r != 2'd0))
    else $error("result without a pending request");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_seen |=> !in_tready)
    else $error("request accepted while previous one still executing");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[SCR_BIT] |->
      (out_tdata[COL_W-1:0] == '0) &&
      (out_tdata[SCR_BIT-1:COL_W] == ROW_W'(ROWS - 1)))
    else $error("scroll left cursor away from bottom-left cell");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[COL_W-1:0]} < (COL_W+1)'(COLS)) &&
                   ({1'b0, out_tdata[SCR_BIT-1:COL_W]} < (ROW_W+1)'(ROWS)))
    else $error("cursor off screen");

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tccs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the text console cursor and scroll engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tccs_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int IN_W  = 32;
  localparam int OUT_W = 32;

  localparam int RANDOM_ITEMS  = 1950;
  localparam int QUIET_TAIL    = 200;     // last requests on each side run without idling
  localparam int HOLD_AT       = 400;     // result count at which the receiver holds off
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 200;     // covers a bottom-row clear plus the pipeline
  localparam int RUN_LIMIT     = 1000000;

  // Packed so that the last field lands in the lowest bits.
  typedef struct packed {
    logic [ROW_W-1:0]  pos_row;
    logic [COL_W-1:0]  pos_col;
    logic [ATTR_W-1:0] attr;
    logic [CH_W-1:0]   ch;
    cmd_t              cmd;
  } console_req_t;

  typedef struct packed {
    logic [ATTR_W-1:0] cell_attr;
    logic [CH_W-1:0]   cell_char;
    logic              scrolled;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } console_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  text_console_cursor_scroll #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the console: cell store (attribute high byte, character low byte) and cursor.
  logic [CELL_W-1:0] shadow_screen [ROWS][COLS];
  logic [COL_W-1:0]  shadow_col = '0;
  logic [ROW_W-1:0]  shadow_row = '0;

  console_req_t pending_requests[$];
  console_res_t awaited_results[$];
  int           n_total = 0;
  int           sent_count = 0;
  int           recv_count = 0;
  int           fail_count = 0;
  int           cycle_count = 0;

  initial begin
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        shadow_screen[r][c] = '0;
  end

  // Move the cursor to column 0 of the next row; scroll when it runs off the bottom.
  function automatic logic advance_row();
    shadow_col = '0;
    if (int'(shadow_row) + 1 >= ROWS) begin
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLS; c++)
          shadow_screen[r][c] = shadow_screen[r+1][c];
      for (int c = 0; c < COLS; c++)
        shadow_screen[ROWS-1][c] = '0;
      shadow_row = ROW_W'(ROWS - 1);
      return 1'b1;
    end
    shadow_row = shadow_row + 1'b1;
    return 1'b0;
  endfunction

  // Apply one request to the shadow console and return the result it must produce.
  function automatic console_res_t apply_console_request(console_req_t rq);
    console_res_t rs;
    logic         on_screen;
    rs = '0;
    on_screen = (int'(rq.pos_col) < COLS) && (int'(rq.pos_row) < ROWS);
    case (rq.cmd)
      CMD_PUT: begin
        if (rq.ch == NEWLINE_CODE) begin
          rs.scrolled = advance_row();
        end else begin
          // the cursor never leaves the screen, so the cell always exists
          shadow_screen[shadow_row][shadow_col] = {rq.attr, rq.ch};
          if (int'(shadow_col) + 1 >= COLS) rs.scrolled = advance_row();
          else shadow_col = shadow_col + 1'b1;
        end
      end
      CMD_READ: begin
        if (on_screen) {rs.cell_attr, rs.cell_char} = shadow_screen[rq.pos_row][rq.pos_col];
      end
      CMD_SETCUR: begin
        if (on_screen) begin
          shadow_col = rq.pos_col;
          shadow_row = rq.pos_row;
        end
      end
      default: begin
        if (on_screen) shadow_screen[rq.pos_row][rq.pos_col] = {rq.attr, rq.ch};
      end
    endcase
    rs.cursor_col = shadow_col;
    rs.cursor_row = shadow_row;
    return rs;
  endfunction

  function automatic void queue_request(cmd_t cmd, int ch, int attr, int col, int row);
    console_req_t rq;
    rq.cmd     = cmd;
    rq.ch      = CH_W'(ch);
    rq.attr    = ATTR_W'(attr);
    rq.pos_col = COL_W'(col);
    rq.pos_row = ROW_W'(row);
    pending_requests.push_back(rq);
  endfunction

  // Idling runs in windows: two noisy stretches of 150 requests, then a quiet one,
  // and none at all near the end of the run.
  function automatic logic idle_allowed(int n);
    return (n < n_total - QUIET_TAIL) && ((n / 150) % 3 != 2);
  endfunction

  // Random position: mostly on the screen, sometimes anywhere the field widths allow.
  function automatic void pick_position(output int col, output int row, input logic low_bias);
    if ($urandom_range(0, 99) < 15) begin
      col = $urandom_range(0, (1 << COL_W) - 1);
      row = $urandom_range(0, (1 << ROW_W) - 1);
    end else if (low_bias && $urandom_range(0, 1) == 0) begin
      col = $urandom_range(60, COLS - 1);
      row = $urandom_range(20, ROWS - 1);
    end else begin
      col = $urandom_range(0, COLS - 1);
      row = $urandom_range(0, ROWS - 1);
    end
  endfunction

  // Sender: hold a request until it is taken, then maybe idle for a burst.
  console_req_t on_bus;
  int           send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(apply_console_request(on_bus));
        sent_count++;
        if (idle_allowed(sent_count) && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 7);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          on_bus = pending_requests.pop_front();
          in_tdata  <= {{(IN_W - $bits(console_req_t)){1'b0}}, on_bus};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest prediction, stall in bursts,
  // and once hold off long enough for the block to back up onto its input.
  console_res_t got, want;
  int           stall_left = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = console_res_t'(out_tdata[$bits(console_res_t)-1:0]);
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
            fail_count++;
          end
          if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
            fail_count++;
          end
          if (got.scrolled !== want.scrolled) begin
            $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
            fail_count++;
          end
          if (got.cell_char !== want.cell_char) begin
            $error("cell_char: expected %0d, got %0d", want.cell_char, got.cell_char);
            fail_count++;
          end
          if (got.cell_attr !== want.cell_attr) begin
            $error("cell_attr: expected %0d, got %0d", want.cell_attr, got.cell_attr);
            fail_count++;
          end
        end
        recv_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_count == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_allowed(recv_count) && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int col, row, run_len;

    // Directed opening: extremes, every command and each corner of the cursor logic.
    queue_request(CMD_READ, 0, 0, 0, 0);                 // store is clear after reset
    queue_request(CMD_PUT, 8'h41, 8'hff, 0, 0);
    queue_request(CMD_PUT, 8'h00, 8'h00, 0, 0);
    queue_request(CMD_READ, 0, 0, 0, 0);
    queue_request(CMD_WRITE, 8'hff, 8'ha5, COLS - 1, ROWS - 1);
    queue_request(CMD_READ, 0, 0, COLS - 1, ROWS - 1);
    queue_request(CMD_WRITE, 8'h11, 8'h22, 127, 31);     // off-screen write, dropped
    queue_request(CMD_READ, 0, 0, 127, 31);              // off-screen reads give zero
    queue_request(CMD_READ, 0, 0, COLS, 0);
    queue_request(CMD_READ, 0, 0, 0, ROWS);
    queue_request(CMD_SETCUR, 0, 0, COLS, 3);            // off-screen position, cursor kept
    queue_request(CMD_SETCUR, 0, 0, 127, 31);
    queue_request(CMD_SETCUR, 0, 0, COLS - 1, 0);
    queue_request(CMD_PUT, 8'h42, 8'h07, 0, 0);          // wrap without a scroll
    queue_request(CMD_SETCUR, 0, 0, COLS - 2, ROWS - 1);
    queue_request(CMD_PUT, 8'h43, 8'h1f, 0, 0);
    queue_request(CMD_PUT, 8'h44, 8'h2e, 0, 0);          // wrap off the bottom: scroll
    queue_request(CMD_READ, 0, 0, COLS - 1, ROWS - 2);
    queue_request(CMD_READ, 0, 0, 0, ROWS - 1);          // new bottom row is clear
    queue_request(CMD_PUT, NEWLINE_CODE, 8'h55, 0, 0);   // newline on the bottom row
    queue_request(CMD_READ, 0, 0, COLS - 1, ROWS - 3);
    queue_request(CMD_SETCUR, 0, 0, 5, 0);
    queue_request(CMD_PUT, NEWLINE_CODE, 0, 0, 0);       // plain newline
    queue_request(CMD_PUT, 8'hff, 8'h00, 0, 0);
    queue_request(CMD_READ, 0, 0, 0, 1);

    // Random part: text runs placed near the bottom so they wrap and scroll,
    // mixed with single requests of every kind.
    n_total = pending_requests.size() + RANDOM_ITEMS;
    while (pending_requests.size() < n_total) begin
      if ($urandom_range(0, 99) < 35) begin
        queue_request(CMD_SETCUR, 0, 0, $urandom_range(0, COLS - 1),
                      $urandom_range(18, ROWS - 1));
        run_len = $urandom_range(3, 40);
        for (int k = 0; k < run_len; k++)
          queue_request(CMD_PUT, ($urandom_range(0, 11) == 0) ? NEWLINE_CODE : $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 31));
      end else begin
        case ($urandom_range(0, 3))
          0: queue_request(CMD_PUT, ($urandom_range(0, 7) == 0) ? NEWLINE_CODE : $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 31));
          1: begin
            pick_position(col, row, 1'b1);
            queue_request(CMD_READ, $urandom_range(0, 255), $urandom_range(0, 255), col, row);
          end
          2: begin
            pick_position(col, row, 1'b1);
            queue_request(CMD_SETCUR, $urandom_range(0, 255), $urandom_range(0, 255), col, row);
          end
          default: begin
            pick_position(col, row, 1'b0);
            queue_request(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 255), col, row);
          end
        endcase
      end
    end
    n_total = pending_requests.size();

    // Hold reset, then release it; the block then clears its store before taking requests.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < n_total || awaited_results.size() != 0) @(posedge clk);
    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
